// ===== rtl/cetc_pkg.sv =====
// cetc_pkg: shared types, calendar constants and reciprocal multipliers
// for the civil/epoch time converter. Used by every module in rtl/.
`default_nettype none

package cetc_pkg;

  // Broken-down UTC time, one field per calendar unit
  typedef struct packed {
    logic [13:0] year;
    logic [3:0]  month;
    logic [4:0]  day;
    logic [4:0]  hour;
    logic [5:0]  minute;
    logic [5:0]  second;
  } civil_t;

  // Register stages inside each conversion path (both paths match)
  localparam int PIPE_DEPTH = 13;

  localparam longint SECS_PER_DAY  = 86400;
  localparam longint SECS_PER_HOUR = 3600;
  localparam longint SECS_PER_MIN  = 60;
  localparam longint DAYS_PER_ERA  = 146097;
  localparam longint DAYS_TO_EPOCH = 719468;
  localparam longint YEARS_PER_ERA = 400;
  localparam longint DAYS_PER_YEAR = 365;
  localparam longint MONTH_JAN_MP  = 10;    // March-based month index of January

  // 86400 = 675 << 7: the low 7 bits of the seconds bypass the day divide
  localparam int     DAY_LSB = 7;
  localparam longint DAY_DIV = SECS_PER_DAY >> DAY_LSB;

  // Bias the signed epoch by a whole number of days so it is never negative
  localparam longint      DAY_BIAS   = ((longint'(1) << 38) + SECS_PER_DAY - 1) / SECS_PER_DAY;
  localparam logic [39:0] EPOCH_BIAS = 40'(DAY_BIAS * SECS_PER_DAY);
  // Whole eras added back so the day count stays non-negative
  localparam longint      ERA_BIAS   = (DAY_BIAS - DAYS_TO_EPOCH + DAYS_PER_ERA - 1) / DAYS_PER_ERA;
  localparam logic [23:0] DAY_ZERO   = 24'(DAYS_TO_EPOCH - DAY_BIAS + ERA_BIAS * DAYS_PER_ERA);
  localparam logic [15:0] YEAR_BIAS  = 16'(ERA_BIAS * YEARS_PER_ERA);

  // Civil-to-epoch: era index is biased by one, fold it into the day offset
  localparam logic signed [24:0] DAY_OFFSET = 25'(DAYS_PER_ERA + DAYS_TO_EPOCH);
  localparam logic signed [17:0] SECS_PER_DAY_S = 18'(SECS_PER_DAY);

  // Reciprocal multipliers: q = (x * RCP) >> SH, exact while x * (d - 1) < 2^SH
  localparam int SH_DAY_HI = 27;
  localparam int SH_DAY_LO = 36;
  localparam int SH_ERA    = 42;
  localparam int SH_HOUR   = 29;
  localparam int SH_MIN    = 18;
  localparam int SH_1460   = 29;
  localparam int SH_36524  = 34;
  localparam int SH_365    = 27;
  localparam int SH_153    = 19;
  localparam int SH_400    = 24;

  localparam logic [17:0] RCP_DAY_HI =
    18'(((longint'(1) << SH_DAY_HI) + DAY_DIV - 1) / DAY_DIV);
  localparam logic [26:0] RCP_DAY_LO =
    27'(((longint'(1) << SH_DAY_LO) + DAY_DIV - 1) / DAY_DIV);
  localparam logic [24:0] RCP_ERA =
    25'(((longint'(1) << SH_ERA) + DAYS_PER_ERA - 1) / DAYS_PER_ERA);
  localparam logic [17:0] RCP_HOUR =
    18'(((longint'(1) << SH_HOUR) + SECS_PER_HOUR - 1) / SECS_PER_HOUR);
  localparam logic [12:0] RCP_MIN =
    13'(((longint'(1) << SH_MIN) + SECS_PER_MIN - 1) / SECS_PER_MIN);
  localparam logic [18:0] RCP_1460 =
    19'(((longint'(1) << SH_1460) + 1460 - 1) / 1460);
  localparam logic [18:0] RCP_36524 =
    19'(((longint'(1) << SH_36524) + 36524 - 1) / 36524);
  localparam logic [18:0] RCP_365 =
    19'(((longint'(1) << SH_365) + DAYS_PER_YEAR - 1) / DAYS_PER_YEAR);
  localparam logic [11:0] RCP_153 =
    12'(((longint'(1) << SH_153) + 153 - 1) / 153);
  localparam logic [15:0] RCP_400 =
    16'(((longint'(1) << SH_400) + YEARS_PER_ERA - 1) / YEARS_PER_ERA);

  // Day of the March-based year on which a month starts: (153 * mp + 2) / 5
  function automatic logic [8:0] month_start(input logic [3:0] mp);
    logic [8:0] r;
    unique case (mp)
      4'd0:    r = 9'd0;
      4'd1:    r = 9'd31;
      4'd2:    r = 9'd61;
      4'd3:    r = 9'd92;
      4'd4:    r = 9'd122;
      4'd5:    r = 9'd153;
      4'd6:    r = 9'd184;
      4'd7:    r = 9'd214;
      4'd8:    r = 9'd245;
      4'd9:    r = 9'd275;
      4'd10:   r = 9'd306;
      4'd11:   r = 9'd337;
      4'd12:   r = 9'd367;
      default: r = 9'd0;
    endcase
    return r;
  endfunction

endpackage

`default_nettype wire

// ===== rtl/cetc_to_epoch.sv =====
// cetc_to_epoch: civil time to epoch seconds, seven compute stages plus
// a delay line to match the epoch-to-civil path. Depends on cetc_pkg.
`default_nettype none

module cetc_to_epoch (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  in_valid,
  input  cetc_pkg::civil_t      civil,
  output logic                  out_valid,
  output logic signed [38:0]    epoch
);

  localparam int PAD = cetc_pkg::PIPE_DEPTH - 7;

  logic [cetc_pkg::PIPE_DEPTH-1:0] vld;

  // stage 1
  logic [14:0]        e1_v;
  logic signed [9:0]  e1_doy;
  logic [4:0]         e1_hour;
  logic [5:0]         e1_min;
  logic [5:0]         e1_sec;
  // stage 2
  logic [14:0]        e2_v;
  logic [5:0]         e2_era;
  logic signed [9:0]  e2_doy;
  logic [16:0]        e2_tod;
  // stage 3
  logic [8:0]         e3_yoe;
  logic [5:0]         e3_era;
  logic signed [9:0]  e3_doy;
  logic [16:0]        e3_tod;
  // stage 4
  logic [5:0]         e4_era;
  logic signed [18:0] e4_doe;
  logic [16:0]        e4_tod;
  // stage 5
  logic signed [24:0] e5_days;
  logic [16:0]        e5_tod;
  // stage 6
  logic [38:0]        e6_prod;
  logic [16:0]        e6_tod;
  // stage 7 and delay line
  logic [38:0]        e7_epoch;
  logic [38:0]        dly [PAD];

  logic               le2;
  logic [3:0]         mp;
  logic [14:0]        v;
  logic signed [9:0]  doy;
  logic [30:0]        prod_era;
  logic [16:0]        tod;
  logic [8:0]         yoe;
  logic [1:0]         yd100;
  logic [17:0]        base;
  logic signed [18:0] doe;
  logic [23:0]        era_days;
  logic signed [24:0] days;
  logic signed [41:0] prod_secs;

  always_comb begin
    // January and February count as months 10 and 11 of the year before
    le2 = (civil.month <= 4'd2);
    mp  = le2 ? 4'(civil.month + 4'd9) : 4'(civil.month - 4'd3);
    v   = 15'(civil.year) + 15'(cetc_pkg::YEARS_PER_ERA) - 15'(le2);
    doy = $signed(10'(cetc_pkg::month_start(mp))) + $signed(10'(civil.day)) - 10'sd1;

    prod_era = 31'(e1_v) * 31'(cetc_pkg::RCP_400);
    tod      = 17'(e1_hour) * 17'(cetc_pkg::SECS_PER_HOUR)
             + 17'(e1_min) * 17'(cetc_pkg::SECS_PER_MIN) + 17'(e1_sec);

    yoe = 9'(e2_v - 15'(e2_era) * 15'(cetc_pkg::YEARS_PER_ERA));

    priority if (e3_yoe >= 9'd300) yd100 = 2'd3;
    else if (e3_yoe >= 9'd200)     yd100 = 2'd2;
    else if (e3_yoe >= 9'd100)     yd100 = 2'd1;
    else                           yd100 = 2'd0;
    base = 18'(18'(e3_yoe) * 18'(cetc_pkg::DAYS_PER_YEAR) + 18'(e3_yoe[8:2]) - 18'(yd100));
    doe  = $signed({1'b0, base}) + 19'(e3_doy);

    era_days = 24'(e4_era) * 24'(cetc_pkg::DAYS_PER_ERA);
    days     = $signed({1'b0, era_days}) + 25'(e4_doe) - cetc_pkg::DAY_OFFSET;

    // wraps modulo 2^39 by keeping the low bits
    prod_secs = e5_days * cetc_pkg::SECS_PER_DAY_S;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else begin
      vld <= {vld[cetc_pkg::PIPE_DEPTH-2:0], in_valid};
    end
  end

  always_ff @(posedge clk) begin
    e1_v     <= v;
    e1_doy   <= doy;
    e1_hour  <= civil.hour;
    e1_min   <= civil.minute;
    e1_sec   <= civil.second;

    e2_v     <= e1_v;
    e2_era   <= prod_era[cetc_pkg::SH_400 +: 6];
    e2_doy   <= e1_doy;
    e2_tod   <= tod;

    e3_yoe   <= yoe;
    e3_era   <= e2_era;
    e3_doy   <= e2_doy;
    e3_tod   <= e2_tod;

    e4_era   <= e3_era;
    e4_doe   <= doe;
    e4_tod   <= e3_tod;

    e5_days  <= days;
    e5_tod   <= e4_tod;

    e6_prod  <= prod_secs[38:0];
    e6_tod   <= e5_tod;

    e7_epoch <= e6_prod + 39'(e6_tod);

    dly[0] <= e7_epoch;
    for (int i = 1; i < PAD; i++) begin
      dly[i] <= dly[i-1];
    end
  end

  assign out_valid = vld[cetc_pkg::PIPE_DEPTH-1];
  assign epoch     = $signed(dly[PAD-1]);

  a_epoch_latency: assert property (@(posedge clk) disable iff (rst)
    in_valid |-> ##(cetc_pkg::PIPE_DEPTH) out_valid)
    else $error("civil-to-epoch item did not emerge after the pipeline depth");

endmodule

`default_nettype wire

// ===== rtl/cetc_to_civil.sv =====
// cetc_to_civil: epoch seconds to civil time, thirteen register stages,
// all divides by reciprocal multiply. Depends on cetc_pkg.
`default_nettype none

module cetc_to_civil (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  in_valid,
  input  logic signed [38:0]    epoch,
  output logic                  out_valid,
  output cetc_pkg::civil_t      civil
);

  logic [cetc_pkg::PIPE_DEPTH-1:0] vld;

  logic [39:0] s1_u;
  logic [39:0] s2_u;
  logic [7:0]  s2_qh;
  logic [7:0]  s3_qh;
  logic [25:0] s3_w;
  logic [6:0]  s3_lo;
  logic [7:0]  s4_qh;
  logic [25:0] s4_w;
  logic [6:0]  s4_lo;
  logic [15:0] s4_ql;
  logic [23:0] s5_z;
  logic [16:0] s5_rem;
  logic [23:0] s6_z;
  logic [16:0] s6_rem;
  logic [6:0]  s6_era;
  logic [4:0]  s6_hour;
  logic [17:0] s7_doe;
  logic [6:0]  s7_era;
  logic [4:0]  s7_hour;
  logic [11:0] s7_ms;
  logic [17:0] s8_doe;
  logic [6:0]  s8_era;
  logic [4:0]  s8_hour;
  logic [11:0] s8_ms;
  logic [5:0]  s8_min;
  logic [7:0]  s8_a;
  logic [2:0]  s8_b;
  logic        s8_c;
  logic [17:0] s9_x;
  logic [17:0] s9_doe;
  logic [6:0]  s9_era;
  logic [4:0]  s9_hour;
  logic [5:0]  s9_min;
  logic [5:0]  s9_sec;
  logic [8:0]  s10_yoe;
  logic [17:0] s10_doe;
  logic [6:0]  s10_era;
  logic [4:0]  s10_hour;
  logic [5:0]  s10_min;
  logic [5:0]  s10_sec;
  logic [8:0]  s11_doy;
  logic [15:0] s11_yr;
  logic [4:0]  s11_hour;
  logic [5:0]  s11_min;
  logic [5:0]  s11_sec;
  logic [3:0]  s12_mp;
  logic [8:0]  s12_doy;
  logic [15:0] s12_yr;
  logic [4:0]  s12_hour;
  logic [5:0]  s12_min;
  logic [5:0]  s12_sec;

  logic [34:0] prod_qh;
  logic [9:0]  rh;
  logic [52:0] prod_ql;
  logic [9:0]  rl;
  logic [48:0] prod_era;
  logic [34:0] prod_hr;
  logic [17:0] doe;
  logic [11:0] ms;
  logic [36:0] prod_a;
  logic [36:0] prod_b;
  logic [24:0] prod_mn;
  logic [17:0] x;
  logic [5:0]  sec;
  logic [36:0] prod_y;
  logic [1:0]  yd100;
  logic [8:0]  doy;
  logic [15:0] yr;
  logic [10:0] n;
  logic [22:0] prod_mp;
  logic        jan_feb;
  logic [3:0]  month;
  logic [4:0]  day;

  always_comb begin
    // day count = (u >> 7) / 675, done as two long-division digits: 8-bit high, 16-bit low
    prod_qh  = 35'(s1_u[39:23]) * 35'(cetc_pkg::RCP_DAY_HI);
    rh       = 10'(s2_u[39:23] - 17'(s2_qh) * 17'(cetc_pkg::DAY_DIV));
    prod_ql  = 53'(s3_w) * 53'(cetc_pkg::RCP_DAY_LO);
    rl       = 10'(s4_w - 26'(s4_ql) * 26'(cetc_pkg::DAY_DIV));

    prod_era = 49'(s5_z) * 49'(cetc_pkg::RCP_ERA);
    prod_hr  = 35'(s5_rem) * 35'(cetc_pkg::RCP_HOUR);

    doe = 18'(s6_z - 24'(s6_era) * 24'(cetc_pkg::DAYS_PER_ERA));
    ms  = 12'(s6_rem - 17'(s6_hour) * 17'(cetc_pkg::SECS_PER_HOUR));

    prod_a  = 37'(s7_doe) * 37'(cetc_pkg::RCP_1460);
    prod_b  = 37'(s7_doe) * 37'(cetc_pkg::RCP_36524);
    prod_mn = 25'(s7_ms) * 25'(cetc_pkg::RCP_MIN);

    x   = s8_doe - 18'(s8_a) + 18'(s8_b) - 18'(s8_c);
    sec = 6'(s8_ms - 12'(s8_min) * 12'(cetc_pkg::SECS_PER_MIN));

    prod_y = 37'(s9_x) * 37'(cetc_pkg::RCP_365);

    priority if (s10_yoe >= 9'd300) yd100 = 2'd3;
    else if (s10_yoe >= 9'd200)     yd100 = 2'd2;
    else if (s10_yoe >= 9'd100)     yd100 = 2'd1;
    else                            yd100 = 2'd0;
    doy = 9'(s10_doe - 18'(s10_yoe) * 18'(cetc_pkg::DAYS_PER_YEAR)
          - 18'(s10_yoe[8:2]) + 18'(yd100));
    yr  = 16'(s10_yoe) + 16'(s10_era) * 16'(cetc_pkg::YEARS_PER_ERA) - cetc_pkg::YEAR_BIAS;

    n       = 11'(s11_doy) * 11'd5 + 11'd2;
    prod_mp = 23'(n) * 23'(cetc_pkg::RCP_153);

    // January and February belong to the next calendar year
    jan_feb = (s12_mp >= 4'(cetc_pkg::MONTH_JAN_MP));
    month   = jan_feb ? 4'(s12_mp - 4'd9) : 4'(s12_mp + 4'd3);
    day     = 5'(s12_doy - cetc_pkg::month_start(s12_mp) + 9'd1);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else begin
      vld <= {vld[cetc_pkg::PIPE_DEPTH-2:0], in_valid};
    end
  end

  always_ff @(posedge clk) begin
    s1_u     <= 40'(epoch) + cetc_pkg::EPOCH_BIAS;

    s2_u     <= s1_u;
    s2_qh    <= prod_qh[cetc_pkg::SH_DAY_HI +: 8];

    s3_qh    <= s2_qh;
    s3_w     <= {rh, s2_u[22:7]};
    s3_lo    <= s2_u[6:0];

    s4_qh    <= s3_qh;
    s4_w     <= s3_w;
    s4_lo    <= s3_lo;
    s4_ql    <= prod_ql[cetc_pkg::SH_DAY_LO +: 16];

    s5_z     <= {s4_qh, s4_ql} + cetc_pkg::DAY_ZERO;
    s5_rem   <= {rl, s4_lo};

    s6_z     <= s5_z;
    s6_rem   <= s5_rem;
    s6_era   <= prod_era[cetc_pkg::SH_ERA +: 7];
    s6_hour  <= prod_hr[cetc_pkg::SH_HOUR +: 5];

    s7_doe   <= doe;
    s7_era   <= s6_era;
    s7_hour  <= s6_hour;
    s7_ms    <= ms;

    s8_doe   <= s7_doe;
    s8_era   <= s7_era;
    s8_hour  <= s7_hour;
    s8_ms    <= s7_ms;
    s8_min   <= prod_mn[cetc_pkg::SH_MIN +: 6];
    s8_a     <= prod_a[cetc_pkg::SH_1460 +: 8];
    s8_b     <= prod_b[cetc_pkg::SH_36524 +: 3];
    s8_c     <= (s7_doe == 18'(cetc_pkg::DAYS_PER_ERA - 1));

    s9_x     <= x;
    s9_doe   <= s8_doe;
    s9_era   <= s8_era;
    s9_hour  <= s8_hour;
    s9_min   <= s8_min;
    s9_sec   <= sec;

    s10_yoe  <= prod_y[cetc_pkg::SH_365 +: 9];
    s10_doe  <= s9_doe;
    s10_era  <= s9_era;
    s10_hour <= s9_hour;
    s10_min  <= s9_min;
    s10_sec  <= s9_sec;

    s11_doy  <= doy;
    s11_yr   <= yr;
    s11_hour <= s10_hour;
    s11_min  <= s10_min;
    s11_sec  <= s10_sec;

    s12_mp   <= prod_mp[cetc_pkg::SH_153 +: 4];
    s12_doy  <= s11_doy;
    s12_yr   <= s11_yr;
    s12_hour <= s11_hour;
    s12_min  <= s11_min;
    s12_sec  <= s11_sec;

    civil.year   <= 14'(s12_yr + 16'(jan_feb));
    civil.month  <= month;
    civil.day    <= day;
    civil.hour   <= s12_hour;
    civil.minute <= s12_min;
    civil.second <= s12_sec;
  end

  assign out_valid = vld[cetc_pkg::PIPE_DEPTH-1];

  a_civil_latency: assert property (@(posedge clk) disable iff (rst)
    in_valid |-> ##(cetc_pkg::PIPE_DEPTH) out_valid)
    else $error("epoch-to-civil item did not emerge after the pipeline depth");

  a_civil_date_range: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (civil.month >= 4'd1 && civil.month <= 4'd12 &&
                   civil.day >= 5'd1 && civil.day <= 5'd31))
    else $error("month or day out of range at the civil output");

  a_civil_time_range: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (civil.hour < 5'd24 && civil.minute < 6'd60 && civil.second < 6'd60))
    else $error("time of day out of range at the civil output");

endmodule

`default_nettype wire

// ===== rtl/civil_epoch_time_converter.sv =====
// civil_epoch_time_converter: top level, splits commands between the two
// conversion pipelines and registers the result. Depends on cetc_pkg,
// cetc_to_epoch and cetc_to_civil.
//
//  channel   handshake     payload
//  command   start, busy   command, in_year .. in_second, in_epoch
//  result    done          out_epoch, out_year .. out_second
//
// One command is taken per clock while busy is low; its result shows with done
// after 13 pipeline stages, set by the chained constant divides, and the output
// register. Either direction has the same latency, so results leave in order.
// busy is high only while rst is held; reset clears the valid bits.
// Results are never held back: each stands for the single cycle of done.
`default_nettype none

module civil_epoch_time_converter (
  input  logic               clk,
  input  logic               rst,
  input  logic               start,
  output logic               busy,
  input  logic               command,
  input  logic [13:0]        in_year,
  input  logic [3:0]         in_month,
  input  logic [4:0]         in_day,
  input  logic [4:0]         in_hour,
  input  logic [5:0]         in_minute,
  input  logic [5:0]         in_second,
  input  logic signed [38:0] in_epoch,
  output logic               done,
  output logic signed [38:0] out_epoch,
  output logic [13:0]        out_year,
  output logic [3:0]         out_month,
  output logic [4:0]         out_day,
  output logic [4:0]         out_hour,
  output logic [5:0]         out_minute,
  output logic [5:0]         out_second
);

  logic                    accept;
  cetc_pkg::civil_t        civ_in;
  logic                    ep_valid;
  logic signed [38:0]      ep_epoch;
  logic                    civ_valid;
  cetc_pkg::civil_t        civ_out;

  assign busy   = rst;
  assign accept = start && !busy;

  always_comb begin
    civ_in.year   = in_year;
    civ_in.month  = in_month;
    civ_in.day    = in_day;
    civ_in.hour   = in_hour;
    civ_in.minute = in_minute;
    civ_in.second = in_second;
  end

  cetc_to_epoch u_to_epoch (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (accept && !command),
    .civil     (civ_in),
    .out_valid (ep_valid),
    .epoch     (ep_epoch)
  );

  cetc_to_civil u_to_civil (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (accept && command),
    .epoch     (in_epoch),
    .out_valid (civ_valid),
    .civil     (civ_out)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      done <= 1'b0;
    end else begin
      done <= ep_valid || civ_valid;
    end
  end

  // zero the fields of the direction not taken
  always_ff @(posedge clk) begin
    if (ep_valid) begin
      out_epoch  <= ep_epoch;
      out_year   <= '0;
      out_month  <= '0;
      out_day    <= '0;
      out_hour   <= '0;
      out_minute <= '0;
      out_second <= '0;
    end else begin
      out_epoch  <= '0;
      out_year   <= civ_out.year;
      out_month  <= civ_out.month;
      out_day    <= civ_out.day;
      out_hour   <= civ_out.hour;
      out_minute <= civ_out.minute;
      out_second <= civ_out.second;
    end
  end

  a_paths_exclusive: assert property (@(posedge clk) disable iff (rst)
    !(ep_valid && civ_valid))
    else $error("both conversion paths delivered in the same cycle");

  a_done_follows_path: assert property (@(posedge clk) disable iff (rst)
    (ep_valid || civ_valid) |=> done)
    else $error("finished conversion was not strobed out");

  a_unused_fields_zero: assert property (@(posedge clk) disable iff (rst)
    done |-> (out_epoch == '0 ||
              (out_year == '0 && out_month == '0 && out_day == '0 &&
               out_hour == '0 && out_minute == '0 && out_second == '0)))
    else $error("result carries fields of both directions");

endmodule

`default_nettype wire
